// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the window sender modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SRSW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define SRSW_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/srsw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window sender package
// Codes, field widths and the structs passed between the sender modules.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int OP_W     = 3;
  localparam int SLOT_W   = 3;
  localparam int LEN_W    = 10;
  localparam int OFFSET_W = 32;
  localparam int TIMER_W  = 8;

  localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_END   = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd2;
  localparam logic [OP_W-1:0] OP_ACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_FORCE = 3'd4;

  localparam logic [2:0] KIND_ASSIGNED = 3'd0;
  localparam logic [2:0] KIND_REJECTED = 3'd1;
  localparam logic [2:0] KIND_SEND     = 3'd2;
  localparam logic [2:0] KIND_FREED    = 3'd3;
  localparam logic [2:0] KIND_COMPLETE = 3'd4;

  typedef struct packed {
    logic [2:0]          kind;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    byte_count;
    logic                last;
  } result_t;

  // Write request into the per-slot timer and length store.
  typedef struct packed {
    logic               timer_we;
    logic               len_we;
    logic [SLOT_W-1:0]  addr;
    logic [TIMER_W-1:0] timer;
    logic [LEN_W-1:0]   length;
  } slot_wr_t;

endpackage

// ===== hw/rtl/srsw_timer_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared timer unit
// One 8-bit increment/decrement with an expiry test, used for slot timers
// during a scan and for the shared seed on loads and acks.
// ----------------------------------------------------------------------------
module srsw_timer_alu (
  input  logic [srsw_pkg::TIMER_W-1:0] a,
  input  logic                         dec,
  output logic [srsw_pkg::TIMER_W-1:0] y,
  output logic                         due
);

  assign y   = dec ? (a - srsw_pkg::TIMER_W'(1)) : (a + srsw_pkg::TIMER_W'(1));
  // A timer is due once it has reached zero or gone negative.
  assign due = (a == '0) || a[srsw_pkg::TIMER_W-1];

endmodule

// ===== hw/rtl/srsw_slot_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot store
// Timer and payload length of each window slot, one write and one read
// address per cycle.
// ----------------------------------------------------------------------------
module srsw_slot_store #(
  parameter int SLOTS = 8
) (
  input  logic                         clk,
  input  srsw_pkg::slot_wr_t           wr,
  input  logic [srsw_pkg::SLOT_W-1:0]  rd_addr,
  output logic [srsw_pkg::TIMER_W-1:0] rd_timer,
  output logic [srsw_pkg::LEN_W-1:0]   rd_length
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [srsw_pkg::TIMER_W-1:0] timer_r [SLOTS];
  logic [srsw_pkg::LEN_W-1:0]   len_r   [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.timer_we) begin
      timer_r[wr.addr[AW-1:0]] <= wr.timer;
    end
    if (wr.len_we) begin
      len_r[wr.addr[AW-1:0]] <= wr.length;
    end
  end

  assign rd_timer  = timer_r[rd_addr[AW-1:0]];
  assign rd_length = len_r[rd_addr[AW-1:0]];

endmodule

// ===== hw/rtl/srsw_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry queue between the sequencer and the result stream, so results
// keep flowing while the sequencer moves on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srsw_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srsw_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output srsw_pkg::result_t out_data
);

  srsw_pkg::result_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  `SRSW_NEVER(a_no_push_full, clk, rst_n, push && full, "result pushed into full buffer")
  `SRSW_ASSERT(a_cnt_range, clk, rst_n, cnt_r != 2'd3, "result buffer count out of range")

endmodule

// ===== hw/rtl/selective_repeat_send_window_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat send window
// Sender side of a retransmit window: load, end of data, tick, ack and force
// commands in; slot assignments, resends, frees and completion out.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and drops in_tready until that
// command has run to its end. Load, end of data, ack and force pass through
// the exec, finish and flush states before in_tready rises again; a tick also
// passes a scan state, in which the one shared timer unit visits the slot
// timers one per cycle while the result stage can take a result. Results
// leave through a two-entry buffer; a full buffer with out_tready low stalls
// the command. The last result of each command carries out_tlast.
`include "assert_macros.svh"

module selective_repeat_send_window_top #(
  parameter int SLOTS       = 8,
  parameter int MAX_PAYLOAD = 1020
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // [9:0] payload_length, [12:10] slot_index, rest zero
  input  logic [2:0]  in_tuser,  // [2:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // [2:0] slot, [34:3] offset, [44:35] byte_count, rest zero
  output logic [2:0]  out_tuser, // [2:0] kind
  output logic        out_tlast
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic [srsw_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [srsw_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [srsw_pkg::SLOT_W-1:0]   idx_r, idx_nxt;
  logic [srsw_pkg::SLOT_W-1:0]   scan_r, scan_nxt;
  logic [SLOTS-1:0]              free_map_r, free_map_nxt;
  logic [srsw_pkg::TIMER_W-1:0]  seed_r, seed_nxt;
  logic [srsw_pkg::OFFSET_W-1:0] offset_r, offset_nxt;
  logic                          ended_r, ended_nxt;
  logic                          fin_r, fin_nxt;
  logic                          pend_v_r, pend_v_nxt;
  srsw_pkg::result_t             pend_r, pend_nxt;

  srsw_pkg::slot_wr_t           wr;
  logic [srsw_pkg::SLOT_W-1:0]  rd_addr;
  logic [srsw_pkg::TIMER_W-1:0] rd_timer;
  logic [srsw_pkg::LEN_W-1:0]   rd_length;

  logic [srsw_pkg::TIMER_W-1:0] alu_a;
  logic                         alu_dec;
  logic [srsw_pkg::TIMER_W-1:0] alu_y;
  logic                         alu_due;

  logic              push;
  srsw_pkg::result_t push_data;
  logic              buf_full;
  srsw_pkg::result_t out_res;

  logic                        can_emit;
  logic                        emit_v;
  srsw_pkg::result_t           emit_d;
  logic                        idx_ok;
  logic [srsw_pkg::SLOT_W-1:0] free_slot;
  logic [srsw_pkg::LEN_W-1:0]  len_sat;

  assign in_tready = (state_r == S_IDLE);
  assign can_emit  = !pend_v_r || !buf_full;
  assign idx_ok    = ({1'b0, idx_r} < 4'(SLOTS));
  assign len_sat   = (32'(len_r) > 32'(MAX_PAYLOAD)) ? srsw_pkg::LEN_W'(MAX_PAYLOAD) : len_r;
  assign rd_addr   = (state_r == S_SCAN) ? scan_r : idx_r;

  // Lowest free slot; only used when at least one slot is free.
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_map_r[i]) begin
        free_slot = srsw_pkg::SLOT_W'(i);
      end
    end
  end

  srsw_timer_alu u_alu (
    .a   (alu_a),
    .dec (alu_dec),
    .y   (alu_y),
    .due (alu_due)
  );

  srsw_slot_store #(.SLOTS(SLOTS)) u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_timer  (rd_timer),
    .rd_length (rd_length)
  );

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    scan_nxt     = scan_r;
    free_map_nxt = free_map_r;
    seed_nxt     = seed_r;
    offset_nxt   = offset_r;
    ended_nxt    = ended_r;
    fin_nxt      = fin_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    wr           = '0;
    alu_a        = seed_r;
    alu_dec      = 1'b0;
    push         = 1'b0;
    push_data    = pend_r;
    emit_v       = 1'b0;
    emit_d       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          len_nxt   = in_tdata[9:0];
          idx_nxt   = in_tdata[12:10];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        alu_dec = (op_r == srsw_pkg::OP_ACK);
        if (can_emit) begin
          state_nxt = S_FIN;
          unique case (op_r)
            srsw_pkg::OP_LOAD: begin
              if (ended_r || (free_map_r == '0)) begin
                emit_v      = 1'b1;
                emit_d.kind = srsw_pkg::KIND_REJECTED;
              end else begin
                wr.timer_we = 1'b1;
                wr.len_we   = 1'b1;
                wr.addr     = free_slot;
                wr.timer    = seed_r;
                wr.length   = len_sat;
                seed_nxt    = alu_y;
                free_map_nxt[free_slot[AW-1:0]] = 1'b0;
                emit_v            = 1'b1;
                emit_d.kind       = srsw_pkg::KIND_ASSIGNED;
                emit_d.slot       = free_slot;
                emit_d.offset     = offset_r;
                emit_d.byte_count = len_sat;
                offset_nxt = offset_r + srsw_pkg::OFFSET_W'(len_sat);
              end
            end
            srsw_pkg::OP_END: begin
              ended_nxt = 1'b1;
            end
            srsw_pkg::OP_TICK: begin
              scan_nxt  = '0;
              state_nxt = S_SCAN;
            end
            srsw_pkg::OP_ACK: begin
              if (idx_ok) begin
                seed_nxt = alu_y;
                if (!free_map_r[idx_r[AW-1:0]]) begin
                  free_map_nxt[idx_r[AW-1:0]] = 1'b1;
                  emit_v            = 1'b1;
                  emit_d.kind       = srsw_pkg::KIND_FREED;
                  emit_d.slot       = idx_r;
                  emit_d.byte_count = rd_length;
                end
              end
            end
            srsw_pkg::OP_FORCE: begin
              if (idx_ok) begin
                wr.timer_we = 1'b1;
                wr.addr     = idx_r;
                wr.timer    = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        alu_a   = rd_timer;
        alu_dec = 1'b1;
        if (can_emit) begin
          if (!free_map_r[scan_r[AW-1:0]]) begin
            wr.timer_we = 1'b1;
            wr.addr     = scan_r;
            if (alu_due) begin
              wr.timer          = seed_r;
              emit_v            = 1'b1;
              emit_d.kind       = srsw_pkg::KIND_SEND;
              emit_d.slot       = scan_r;
              emit_d.byte_count = rd_length;
            end else begin
              wr.timer = alu_y;
            end
          end
          scan_nxt = scan_r + srsw_pkg::SLOT_W'(1);
          if (scan_r == srsw_pkg::SLOT_W'(SLOTS - 1)) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (can_emit) begin
          if (ended_r && !fin_r && (&free_map_r)) begin
            fin_nxt     = 1'b1;
            emit_v      = 1'b1;
            emit_d.kind = srsw_pkg::KIND_COMPLETE;
          end
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (!buf_full) begin
          push           = 1'b1;
          push_data.last = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new result pushes out the held one, which therefore was not the last.
    if (emit_v) begin
      if (pend_v_r) begin
        push           = 1'b1;
        push_data.last = 1'b0;
      end
      pend_nxt   = emit_d;
      pend_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      free_map_r <= '1;
      seed_r     <= '0;
      offset_r   <= '0;
      ended_r    <= 1'b0;
      fin_r      <= 1'b0;
      pend_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      free_map_r <= free_map_nxt;
      seed_r     <= seed_nxt;
      offset_r   <= offset_nxt;
      ended_r    <= ended_nxt;
      fin_r      <= fin_nxt;
      pend_v_r   <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    scan_r <= scan_nxt;
    pend_r <= pend_nxt;
  end

  srsw_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (buf_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {3'b000, out_res.byte_count, out_res.offset, out_res.slot};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  `SRSW_NEVER(a_idle_no_pend, clk, rst_n, (state_r == S_IDLE) && pend_v_r, "held result left behind")
  `SRSW_ASSERT(a_fin_needs_end, clk, rst_n, !fin_r || ended_r, "completion without end of data")
  `SRSW_ASSERT(a_scan_on_tick, clk, rst_n, (state_r != S_SCAN) || (op_r == srsw_pkg::OP_TICK), "scan outside a tick")
  `SRSW_ASSERT(a_fin_once, clk, rst_n, $past(fin_r) |-> fin_r, "completion flag cleared")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat send window testbench
// Drives load, end of data, tick, ack and force words into the window sender
// and checks every result word against a cycle-free model of the window held
// here. A directed table comes first, then a sweep of acks that drives the
// timer seed well below zero, then random traffic with stalls on both sides,
// and last the end-of-data drain that leads to the completion word.
// ----------------------------------------------------------------------------
module testbench;
  import srsw_pkg::*;

  localparam int SLOTS        = 8;
  localparam int MAX_PAYLOAD  = 1020;
  localparam int RANDOM_WORDS = 100;
  localparam int SWEEP_ACKS   = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = SLOTS + 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int NUM_ROWS     = 25;

  // Opcodes that the block must ignore.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [LEN_W-1:0]    len;
    logic [SLOT_W-1:0]   idx;
    bit                  typed;
    logic [2:0]          kind;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    count;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [9:0] payload_length, [12:10] slot_index, rest zero
  logic [2:0]  in_tuser;   // [2:0] opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [2:0] slot, [34:3] offset, [44:35] byte_count, rest zero
  logic [2:0]  out_tuser;  // [2:0] kind
  logic        out_tlast;

  // Window model state.
  logic [SLOTS-1:0]          win_free;
  logic signed [TIMER_W-1:0] win_seed;
  logic signed [TIMER_W-1:0] win_timer [SLOTS];
  logic [LEN_W-1:0]          win_len [SLOTS];
  logic [OFFSET_W-1:0]       win_offset;
  bit                        win_ended;
  bit                        win_done;

  result_t step_results[$];
  result_t pending_results[$];

  int  mismatches = 0;
  int  stall_cycles = 0;
  bit  calm;
  bit  hold_cmd;
  bit  hold_served;

  // Words with a typed result give exactly one result word.
  plan_row_t plan [NUM_ROWS] = '{
    '{OP_ACK,      10'd0,    3'd3, 1'b0, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0},
    '{OP_FORCE,    10'd0,    3'd5, 1'b0, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0},
    '{OP_SPARE_LO, 10'd0,    3'd0, 1'b0, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0},
    '{OP_SPARE_HI, 10'd1023, 3'd7, 1'b0, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0},
    '{OP_TICK,     10'd0,    3'd0, 1'b0, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0},
    '{OP_LOAD,     10'd0,    3'd0, 1'b1, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0},
    '{OP_LOAD,     10'd1023, 3'd0, 1'b1, KIND_ASSIGNED, 3'd1, 32'd0,    10'd1020},
    '{OP_LOAD,     10'd1020, 3'd0, 1'b1, KIND_ASSIGNED, 3'd2, 32'd1020, 10'd1020},
    '{OP_LOAD,     10'd341,  3'd0, 1'b1, KIND_ASSIGNED, 3'd3, 32'd2040, 10'd341},
    '{OP_LOAD,     10'd682,  3'd0, 1'b1, KIND_ASSIGNED, 3'd4, 32'd2381, 10'd682},
    '{OP_LOAD,     10'd1,    3'd0, 1'b1, KIND_ASSIGNED, 3'd5, 32'd3063, 10'd1},
    '{OP_LOAD,     10'd512,  3'd0, 1'b1, KIND_ASSIGNED, 3'd6, 32'd3064, 10'd512},
    '{OP_LOAD,     10'd7,    3'd0, 1'b1, KIND_ASSIGNED, 3'd7, 32'd3576, 10'd7},
    '{OP_LOAD,     10'd100,  3'd0, 1'b1, KIND_REJECTED, 3'd0, 32'd0,    10'd0},
    '{OP_TICK,     10'd0,    3'd0, 1'b0, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0},
    '{OP_FORCE,    10'd0,    3'd7, 1'b0, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0},
    '{OP_TICK,     10'd0,    3'd0, 1'b0, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0},
    '{OP_ACK,      10'd0,    3'd2, 1'b1, KIND_FREED,    3'd2, 32'd0,    10'd1020},
    '{OP_ACK,      10'd0,    3'd2, 1'b0, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0},
    '{OP_LOAD,     10'd3,    3'd0, 1'b1, KIND_ASSIGNED, 3'd2, 32'd3583, 10'd3},
    '{OP_ACK,      10'd0,    3'd0, 1'b1, KIND_FREED,    3'd0, 32'd0,    10'd0},
    '{OP_ACK,      10'd0,    3'd1, 1'b1, KIND_FREED,    3'd1, 32'd0,    10'd1020},
    '{OP_TICK,     10'd0,    3'd0, 1'b0, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0},
    '{OP_FORCE,    10'd0,    3'd6, 1'b0, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0},
    '{OP_TICK,     10'd0,    3'd0, 1'b0, KIND_ASSIGNED, 3'd0, 32'd0,    10'd0}
  };

  selective_repeat_send_window_top #(
    .SLOTS       (SLOTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_result(logic [2:0] kind, logic [SLOT_W-1:0] slot,
                                     logic [OFFSET_W-1:0] offset,
                                     logic [LEN_W-1:0] count);
    result_t r;
    r.kind       = kind;
    r.slot       = slot;
    r.offset     = offset;
    r.byte_count = count;
    r.last       = 1'b0;
    step_results.push_back(r);
  endfunction

  // Applies one command word to the window model and collects its results.
  function automatic void window_step(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                                      logic [SLOT_W-1:0] idx);
    int s;
    logic [LEN_W-1:0] blen;
    step_results.delete();
    case (op)
      OP_LOAD: begin
        if (win_ended || win_free == '0) begin
          add_result(KIND_REJECTED, '0, '0, '0);
        end else begin
          s = 0;
          while (!win_free[s]) s++;
          blen = (len > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : len;
          win_free[s]  = 1'b0;
          win_len[s]   = blen;
          win_timer[s] = win_seed;
          win_seed     = win_seed + TIMER_W'(1);
          add_result(KIND_ASSIGNED, SLOT_W'(s), win_offset, blen);
          win_offset = win_offset + OFFSET_W'(blen);
        end
      end
      OP_END: begin
        win_ended = 1'b1;
      end
      OP_TICK: begin
        for (s = 0; s < SLOTS; s++) begin
          if (!win_free[s]) begin
            // A timer at zero or below is due; the seed reloads it.
            if (win_timer[s] <= 0) begin
              win_timer[s] = win_seed;
              add_result(KIND_SEND, SLOT_W'(s), '0, win_len[s]);
            end else begin
              win_timer[s] = win_timer[s] - TIMER_W'(1);
            end
          end
        end
      end
      OP_ACK: begin
        win_seed = win_seed - TIMER_W'(1);
        if (!win_free[idx]) begin
          win_free[idx] = 1'b1;
          add_result(KIND_FREED, idx, '0, win_len[idx]);
        end
      end
      OP_FORCE: begin
        win_timer[idx] = '0;
      end
      default: begin
      end
    endcase
    if (win_ended && !win_done && win_free == '1) begin
      win_done = 1'b1;
      add_result(KIND_COMPLETE, '0, '0, '0);
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  task automatic send_word(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                           logic [SLOT_W-1:0] idx, bit typed, result_t want);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {3'b000, idx, len};
    do @(posedge clk); while (!in_tready);
    window_step(op, len, idx);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  // Stops offering words until every expected result has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [OP_W-1:0] OP_LOGIC_SPARE();
    return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  task automatic send_random_word();
    int roll;
    int pick;
    logic [OP_W-1:0]   op;
    logic [LEN_W-1:0]  len;
    roll = $urandom_range(0, 99);
    if (roll < 35)      op = OP_LOAD;
    else if (roll < 60) op = OP_TICK;
    else if (roll < 87) op = OP_ACK;
    else if (roll < 95) op = OP_FORCE;
    else                op = OP_LOGIC_SPARE();
    pick = $urandom_range(0, 9);
    if (pick == 0)      len = '1;
    else if (pick == 1) len = LEN_W'(MAX_PAYLOAD);
    else                len = LEN_W'($urandom_range(0, 1023));
    send_word(op, len, SLOT_W'($urandom_range(0, SLOTS - 1)), 1'b0, '0);
  endtask

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    out_tready  = 1'b0;
    hold_served = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cmd && !hold_served) begin
        hold_served = 1'b1;
        out_tready  = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready = calm || ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind       = out_tuser;
      got.slot       = out_tdata[2:0];
      got.offset     = out_tdata[34:3];
      got.byte_count = out_tdata[44:35];
      got.last       = out_tlast;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: kind %0d slot %0d offset %0d count %0d last %0d",
                   got.kind, got.slot, got.offset, got.byte_count, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected kind %0d slot %0d offset %0d count %0d last %0d,",
                      " got kind %0d slot %0d offset %0d count %0d last %0d"},
                     want.kind, want.slot, want.offset, want.byte_count, want.last,
                     got.kind, got.slot, got.offset, got.byte_count, got.last);
        end
      end
    end
  end

  // Ends the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAIL selective_repeat_send_window_top");
        $finish;
      end
    end
  end

  initial begin
    result_t want;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    calm      = 1'b0;
    hold_cmd  = 1'b0;
    win_free   = '1;
    win_seed   = '0;
    win_offset = '0;
    win_ended  = 1'b0;
    win_done   = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      win_timer[s] = '0;
      win_len[s]   = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[r]) begin
      want.kind       = plan[r].kind;
      want.slot       = plan[r].slot;
      want.offset     = plan[r].offset;
      want.byte_count = plan[r].count;
      want.last       = 1'b1;
      send_word(plan[r].op, plan[r].len, plan[r].idx, plan[r].typed, want);
    end
    wait_drained();

    // Acks alone walk the seed well below zero, so later loads start due.
    calm = 1'b1;
    for (int k = 0; k < SWEEP_ACKS; k++)
      send_word(OP_ACK, LEN_W'($urandom_range(0, 1023)), SLOT_W'(k % SLOTS), 1'b0, '0);
    calm = 1'b0;
    wait_drained();

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k == 20) hold_cmd = 1'b1;
      if (k == 50) wait_drained();
      calm = (k >= 60 && k < 90);
      send_random_word();
    end
    calm = 1'b0;
    wait_drained();

    // End of data with slots still busy; completion follows the last free.
    for (int k = 0; k < 3; k++) send_word(OP_LOAD, 10'd200, '0, 1'b0, '0);
    send_word(OP_END, '0, '0, 1'b0, '0);
    send_word(OP_LOAD, 10'd5, '0, 1'b0, '0);
    send_word(OP_TICK, '0, '0, 1'b0, '0);
    for (int k = 0; k < SLOTS; k++) send_word(OP_ACK, '0, SLOT_W'(k), 1'b0, '0);
    send_word(OP_END, '0, '0, 1'b0, '0);
    send_word(OP_ACK, '0, 3'd4, 1'b0, '0);
    send_word(OP_TICK, '0, '0, 1'b0, '0);
    send_word(OP_FORCE, '0, 3'd1, 1'b0, '0);
    wait_drained();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS selective_repeat_send_window_top");
    end else begin
      $display("FAIL selective_repeat_send_window_top");
    end
    $finish;
  end

endmodule
